[hdl/asf_pkg.sv]
// ----------------------------------------------------------------------------
// asf_pkg: shared types and constants of the ARP spoofing filter
// Holds the table command token, the control states and the protocol codes.
// ----------------------------------------------------------------------------
package asf_pkg;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int CFG_IDX_W = 8;

    localparam logic [1:0] HOOK_INPUT   = 2'd0;
    localparam logic [1:0] HOOK_OUTPUT  = 2'd1;
    localparam logic [1:0] HOOK_FORWARD = 2'd2;

    localparam logic [1:0] VERDICT_DROP     = 2'd0;
    localparam logic [1:0] VERDICT_CONTINUE = 2'd2;

    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;
    localparam logic [15:0] HW_ETHERNET = 16'd1;
    localparam logic [15:0] HW_IEEE802  = 16'd6;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [MAC_W-1:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

    localparam logic [3:0] CAUSE_PASSED        = 4'd0;
    localparam logic [3:0] CAUSE_SRC_MISMATCH  = 4'd1;
    localparam logic [3:0] CAUSE_DST_MISMATCH  = 4'd2;
    localparam logic [3:0] CAUSE_LOCAL_SENDER  = 4'd3;
    localparam logic [3:0] CAUSE_REQ_NOT_BCAST = 4'd4;
    localparam logic [3:0] CAUSE_REQ_TMAC_SET  = 4'd5;
    localparam logic [3:0] CAUSE_REPLY_BCAST   = 4'd6;
    localparam logic [3:0] CAUSE_FWD_TO_LOCAL  = 4'd7;
    localparam logic [3:0] CAUSE_REQ_ON_INPUT  = 4'd8;
    localparam logic [3:0] CAUSE_UNSOLICITED   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_HOOK      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_ACTION     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP_ENABLE = 8'd3;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_SEARCH,
        CMD_INSERT,
        CMD_REMOVE
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic            live;
        cmd_t            cmd;
        logic [IP_W-1:0] ip;
        logic            hit;
        logic            free;
        logic            done;
    } token_t;

endpackage

[hdl/asf_cell.sv]
// ----------------------------------------------------------------------------
// asf_cell: one table entry
// Holds one address with its valid bit and applies the passing token to it.
// ----------------------------------------------------------------------------
module asf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  asf_pkg::token_t tok_in,
    output asf_pkg::token_t tok_out
);

    logic [asf_pkg::IP_W-1:0] addr_reg;
    logic [asf_pkg::IP_W-1:0] addr_next;
    logic                     valid_reg;
    logic                     valid_next;
    asf_pkg::token_t          tok_reg;
    asf_pkg::token_t          tok_next;
    logic                     match;

    assign match = valid_reg && (addr_reg == tok_in.ip);

    always_comb
    begin
        addr_next  = addr_reg;
        valid_next = valid_reg;
        tok_next   = tok_in;
        if (tok_in.live)
        begin
            case (tok_in.cmd)
                asf_pkg::CMD_SEARCH:
                begin
                    tok_next.hit  = tok_in.hit | match;
                    tok_next.free = tok_in.free | ~valid_reg;
                end
                asf_pkg::CMD_INSERT:
                begin
                    if (!tok_in.done && !valid_reg)
                    begin
                        valid_next    = 1'b1;
                        addr_next     = tok_in.ip;
                        tok_next.done = 1'b1;
                    end
                end
                asf_pkg::CMD_REMOVE:
                begin
                    if (match)
                    begin
                        valid_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    assign tok_out = tok_reg;

endmodule

[hdl/asf_chain.sv]
// ----------------------------------------------------------------------------
// asf_chain: one address table as a row of cells
// A token enters the first cell and leaves the last, registered in each cell.
// ----------------------------------------------------------------------------
module asf_chain #(
    parameter int DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  asf_pkg::token_t tok_in,
    output asf_pkg::token_t tok_out
);

    asf_pkg::token_t link [DEPTH+1];

    assign link[0] = tok_in;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        asf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tok_out = link[DEPTH];

endmodule

[hdl/arp_spoof_filter.sv]
// ----------------------------------------------------------------------------
// arp_spoof_filter: ARP spoofing filter
// Checks one parsed ARP packet against header rules and request/response
// tables and returns a verdict with its cause.
//
// Channel   Handshake              Contents
// in        in_valid / in_ready    ARP header fields of one packet
// out       out_valid / out_ready  verdict, cause, insert_lost
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A packet that needs no table work goes straight to the finish state.
// A table packet passes a token twice through both cell rows, a search pass and
// then an update pass. Each result waits for a free output register.
// One packet is in work at a time; in_ready is high only while idle.
// A waiting result holds in the output register while the next packet works.
// Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_spoof_filter #(
    parameter int REQUEST_ENTRIES  = 64,
    parameter int RESPONSE_ENTRIES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [15:0]                     hw_type,
    input  logic [15:0]                     proto_type,
    input  logic [15:0]                     arp_opcode,
    input  logic [asf_pkg::MAC_W-1:0]       eth_source,
    input  logic [asf_pkg::MAC_W-1:0]       eth_dest,
    input  logic [asf_pkg::MAC_W-1:0]       sender_mac,
    input  logic [asf_pkg::IP_W-1:0]        sender_ip,
    input  logic [asf_pkg::MAC_W-1:0]       target_mac,
    input  logic [asf_pkg::IP_W-1:0]        target_ip,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      verdict,
    output logic [3:0]                      cause,
    output logic                            insert_lost,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asf_pkg::IP_W-1:0]        cfg_data
);

    asf_pkg::state_t           state_reg;
    asf_pkg::state_t           state_next;
    logic                      launch_reg;
    logic                      launch_next;
    logic                      back_req_reg;
    logic                      back_req_next;
    logic                      back_rsp_reg;
    logic                      back_rsp_next;
    logic                      reply_reg;
    logic                      reply_next;
    logic [asf_pkg::IP_W-1:0]  key_reg;
    logic [asf_pkg::IP_W-1:0]  key_next;
    logic [3:0]                cause_reg;
    logic [3:0]                cause_next;
    logic                      lost_reg;
    logic                      lost_next;
    asf_pkg::cmd_t             req_cmd_reg;
    asf_pkg::cmd_t             req_cmd_next;
    asf_pkg::cmd_t             rsp_cmd_reg;
    asf_pkg::cmd_t             rsp_cmd_next;
    logic                      req_hit_reg;
    logic                      req_hit_next;
    logic                      req_free_reg;
    logic                      req_free_next;
    logic                      rsp_hit_reg;
    logic                      rsp_hit_next;
    logic                      rsp_free_reg;
    logic                      rsp_free_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [1:0]                verdict_reg;
    logic [1:0]                verdict_next;
    logic [3:0]                cause_out_reg;
    logic [3:0]                cause_out_next;
    logic                      lost_out_reg;
    logic                      lost_out_next;

    logic [1:0]                chain_hook_reg;
    logic [1:0]                fail_action_reg;
    logic [asf_pkg::IP_W-1:0]  local_ip_reg;
    logic                      local_ip_enable_reg;

    logic                      in_xfer;
    logic                      both_back;
    logic                      out_free;
    logic                      acc_table;
    logic                      acc_reply;
    logic [3:0]                acc_cause;
    logic [3:0]                hdr_cause;
    logic                      type_ok;
    logic                      sip_local;
    logic                      tip_local;

    asf_pkg::token_t           req_tok_in;
    asf_pkg::token_t           rsp_tok_in;
    asf_pkg::token_t           req_tok_out;
    asf_pkg::token_t           rsp_tok_out;

    assign in_ready  = (state_reg == asf_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign both_back = back_req_reg && back_rsp_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign cause       = cause_out_reg;
    assign insert_lost = lost_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_hook_reg      <= asf_pkg::HOOK_INPUT;
            fail_action_reg     <= asf_pkg::VERDICT_DROP;
            local_ip_reg        <= '0;
            local_ip_enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asf_pkg::CFG_CHAIN_HOOK:      chain_hook_reg      <= cfg_data[1:0];
                asf_pkg::CFG_FAIL_ACTION:     fail_action_reg     <= cfg_data[1:0];
                asf_pkg::CFG_LOCAL_IP:        local_ip_reg        <= cfg_data;
                asf_pkg::CFG_LOCAL_IP_ENABLE: local_ip_enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Header checks in their order of priority; the first one that fails decides.
    always_comb
    begin
        type_ok   = ((hw_type == asf_pkg::HW_ETHERNET) || (hw_type == asf_pkg::HW_IEEE802)) &&
                    (proto_type == asf_pkg::PROTO_IPV4);
        sip_local = local_ip_enable_reg && (sender_ip == local_ip_reg);
        tip_local = local_ip_enable_reg && (target_ip == local_ip_reg);
        hdr_cause = asf_pkg::CAUSE_PASSED;
        if (chain_hook_reg == asf_pkg::HOOK_OUTPUT)
            hdr_cause = asf_pkg::CAUSE_PASSED;
        else if (eth_source != sender_mac)
            hdr_cause = asf_pkg::CAUSE_SRC_MISMATCH;
        else if ((arp_opcode == asf_pkg::OP_REPLY) && (eth_dest != target_mac))
            hdr_cause = asf_pkg::CAUSE_DST_MISMATCH;
        else if (sip_local)
            hdr_cause = asf_pkg::CAUSE_LOCAL_SENDER;
        else if ((arp_opcode == asf_pkg::OP_REQUEST) && (eth_dest != asf_pkg::MAC_BROADCAST))
            hdr_cause = asf_pkg::CAUSE_REQ_NOT_BCAST;
        else if ((arp_opcode == asf_pkg::OP_REQUEST) && (target_mac != '0))
            hdr_cause = asf_pkg::CAUSE_REQ_TMAC_SET;
        else if ((arp_opcode == asf_pkg::OP_REPLY) && (eth_dest == asf_pkg::MAC_BROADCAST))
            hdr_cause = asf_pkg::CAUSE_REPLY_BCAST;
        else if ((arp_opcode == asf_pkg::OP_REPLY) &&
                 (chain_hook_reg == asf_pkg::HOOK_FORWARD) && tip_local)
            hdr_cause = asf_pkg::CAUSE_FWD_TO_LOCAL;

        acc_cause = asf_pkg::CAUSE_PASSED;
        acc_table = 1'b0;
        acc_reply = 1'b0;
        if (type_ok)
        begin
            if (hdr_cause != asf_pkg::CAUSE_PASSED)
                acc_cause = hdr_cause;
            else if (arp_opcode == asf_pkg::OP_REQUEST)
            begin
                if (chain_hook_reg == asf_pkg::HOOK_INPUT)
                    acc_cause = asf_pkg::CAUSE_REQ_ON_INPUT;
                else if ((chain_hook_reg == asf_pkg::HOOK_OUTPUT) ||
                         (chain_hook_reg == asf_pkg::HOOK_FORWARD))
                    acc_table = 1'b1;
            end
            else if ((arp_opcode == asf_pkg::OP_REPLY) &&
                     ((chain_hook_reg == asf_pkg::HOOK_INPUT) ||
                      (chain_hook_reg == asf_pkg::HOOK_FORWARD)))
            begin
                acc_table = 1'b1;
                acc_reply = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            asf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = acc_table ? asf_pkg::ST_SEARCH : asf_pkg::ST_FINISH;
            end
            asf_pkg::ST_SEARCH:
            begin
                if (both_back)
                    state_next = asf_pkg::ST_UPDATE;
            end
            asf_pkg::ST_UPDATE:
            begin
                if (both_back)
                    state_next = asf_pkg::ST_FINISH;
            end
            asf_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = asf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = asf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        launch_next    = 1'b0;
        back_req_next  = back_req_reg || req_tok_out.live;
        back_rsp_next  = back_rsp_reg || rsp_tok_out.live;
        reply_next     = reply_reg;
        key_next       = key_reg;
        cause_next     = cause_reg;
        lost_next      = lost_reg;
        req_cmd_next   = req_cmd_reg;
        rsp_cmd_next   = rsp_cmd_reg;
        req_hit_next   = req_tok_out.live ? req_tok_out.hit  : req_hit_reg;
        req_free_next  = req_tok_out.live ? req_tok_out.free : req_free_reg;
        rsp_hit_next   = rsp_tok_out.live ? rsp_tok_out.hit  : rsp_hit_reg;
        rsp_free_next  = rsp_tok_out.live ? rsp_tok_out.free : rsp_free_reg;
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        cause_out_next = cause_out_reg;
        lost_out_next  = lost_out_reg;

        case (state_reg)
            asf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    reply_next    = acc_reply;
                    key_next      = acc_reply ? sender_ip : target_ip;
                    cause_next    = acc_cause;
                    lost_next     = 1'b0;
                    launch_next   = acc_table;
                    back_req_next = 1'b0;
                    back_rsp_next = 1'b0;
                end
            end
            asf_pkg::ST_SEARCH:
            begin
                if (both_back)
                begin
                    launch_next   = 1'b1;
                    back_req_next = 1'b0;
                    back_rsp_next = 1'b0;
                    req_cmd_next  = asf_pkg::CMD_NOP;
                    rsp_cmd_next  = asf_pkg::CMD_NOP;
                    if (!reply_reg)
                    begin
                        if (!req_hit_reg)
                        begin
                            req_cmd_next = asf_pkg::CMD_INSERT;
                            lost_next    = !req_free_reg;
                        end
                    end
                    else if (req_hit_reg)
                    begin
                        req_cmd_next = asf_pkg::CMD_REMOVE;
                        if (!rsp_hit_reg)
                        begin
                            rsp_cmd_next = asf_pkg::CMD_INSERT;
                            lost_next    = !rsp_free_reg;
                        end
                    end
                    else if (!rsp_hit_reg)
                    begin
                        cause_next = asf_pkg::CAUSE_UNSOLICITED;
                    end
                end
            end
            asf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cause_out_next = cause_reg;
                    lost_out_next  = lost_reg;
                    if (cause_reg == asf_pkg::CAUSE_PASSED)
                        verdict_next = asf_pkg::VERDICT_CONTINUE;
                    else if (fail_action_reg <= asf_pkg::VERDICT_CONTINUE)
                        verdict_next = fail_action_reg;
                    else
                        verdict_next = asf_pkg::VERDICT_DROP;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asf_pkg::ST_IDLE;
            launch_reg    <= 1'b0;
            back_req_reg  <= 1'b0;
            back_rsp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            back_req_reg  <= back_req_next;
            back_rsp_reg  <= back_rsp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reply_reg     <= reply_next;
        key_reg       <= key_next;
        cause_reg     <= cause_next;
        lost_reg      <= lost_next;
        req_cmd_reg   <= req_cmd_next;
        rsp_cmd_reg   <= rsp_cmd_next;
        req_hit_reg   <= req_hit_next;
        req_free_reg  <= req_free_next;
        rsp_hit_reg   <= rsp_hit_next;
        rsp_free_reg  <= rsp_free_next;
        verdict_reg   <= verdict_next;
        cause_out_reg <= cause_out_next;
        lost_out_reg  <= lost_out_next;
    end

    always_comb
    begin
        req_tok_in      = '0;
        req_tok_in.live = launch_reg;
        req_tok_in.ip   = key_reg;
        req_tok_in.cmd  = (state_reg == asf_pkg::ST_SEARCH) ? asf_pkg::CMD_SEARCH : req_cmd_reg;
        rsp_tok_in      = '0;
        rsp_tok_in.live = launch_reg;
        rsp_tok_in.ip   = key_reg;
        rsp_tok_in.cmd  = (state_reg == asf_pkg::ST_SEARCH) ? asf_pkg::CMD_SEARCH : rsp_cmd_reg;
    end

    asf_chain #(
        .DEPTH (REQUEST_ENTRIES)
    ) u_req_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (req_tok_in),
        .tok_out (req_tok_out)
    );

    asf_chain #(
        .DEPTH (RESPONSE_ENTRIES)
    ) u_rsp_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (rsp_tok_in),
        .tok_out (rsp_tok_out)
    );

endmodule

[hdl/asf_checker.sv]
// ----------------------------------------------------------------------------
// asf_checker: port-level checks of the ARP spoofing filter
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module asf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict,
    input logic [3:0] cause,
    input logic       insert_lost
);

    // One packet at a time: a transfer closes the input until its work is done.
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted a second packet while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(verdict) && $stable(cause) && $stable(insert_lost)))
        else $error("stalled result changed");

    a_pass_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cause == asf_pkg::CAUSE_PASSED)) |->
            (verdict == asf_pkg::VERDICT_CONTINUE))
        else $error("passed packet without continue verdict");

    a_lost_only_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && insert_lost) |-> (cause == asf_pkg::CAUSE_PASSED))
        else $error("lost insert reported on a rejected packet");

endmodule

bind arp_spoof_filter asf_checker u_asf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict),
    .cause       (cause),
    .insert_lost (insert_lost)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ARP spoofing filter
// Sends parsed ARP packets under a series of filter settings, predicts each
// verdict with its own copy of the request and response address tables, and
// compares every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import asf_pkg::*;

    localparam int REQ_ENTRIES  = 64;
    localparam int RSP_ENTRIES  = 64;
    localparam int REQ_TBL      = 0;
    localparam int RSP_TBL      = 1;
    localparam int POOL_SIZE    = 96;
    localparam logic [IP_W-1:0] POOL_BASE = 32'h0A00_0100;
    localparam logic [1:0] HOOK_UNKNOWN   = 2'd3;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [1:0] ACTION_UNKNOWN = 2'd3;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 137;
    localparam int HOLD_CYCLES     = 600;

    typedef struct {
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [15:0]      arp_opcode;
        logic [MAC_W-1:0] eth_source;
        logic [MAC_W-1:0] eth_dest;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] target_mac;
        logic [IP_W-1:0]  target_ip;
    } arp_pkt_t;

    typedef struct {
        logic [1:0] verdict;
        logic [3:0] cause;
        logic       insert_lost;
    } filter_result_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [15:0]          hw_type     = '0;
    logic [15:0]          proto_type  = '0;
    logic [15:0]          arp_opcode  = '0;
    logic [MAC_W-1:0]     eth_source  = '0;
    logic [MAC_W-1:0]     eth_dest    = '0;
    logic [MAC_W-1:0]     sender_mac  = '0;
    logic [IP_W-1:0]      sender_ip   = '0;
    logic [MAC_W-1:0]     target_mac  = '0;
    logic [IP_W-1:0]      target_ip   = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [1:0]           verdict;
    logic [3:0]           cause;
    logic                 insert_lost;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [IP_W-1:0]      cfg_data    = '0;

    arp_pkt_t       packets_to_send[$];
    filter_result_t verdicts_due[$];
    arp_pkt_t       pkt_on_wire;
    filter_result_t due_now;

    logic [IP_W-1:0] tbl_ip   [2][64];
    bit              tbl_live [2][64];

    logic [1:0]      cur_hook     = HOOK_INPUT;
    logic [1:0]      cur_action   = VERDICT_DROP;
    logic [IP_W-1:0] cur_local_ip = '0;
    logic            cur_local_en = 1'b0;

    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    logic        hold_arm        = 1'b0;
    logic        hold_fired      = 1'b0;
    int          hold_left       = 0;
    int          err_count       = 0;
    int          results_checked = 0;
    int          lost_seen       = 0;
    int          settings_used   = 0;
    logic [15:0] causes_seen     = '0;

    arp_spoof_filter #(
        .REQUEST_ENTRIES  (REQ_ENTRIES),
        .RESPONSE_ENTRIES (RSP_ENTRIES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .hw_type     (hw_type),
        .proto_type  (proto_type),
        .arp_opcode  (arp_opcode),
        .eth_source  (eth_source),
        .eth_dest    (eth_dest),
        .sender_mac  (sender_mac),
        .sender_ip   (sender_ip),
        .target_mac  (target_mac),
        .target_ip   (target_ip),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .verdict     (verdict),
        .cause       (cause),
        .insert_lost (insert_lost),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_local(logic [IP_W-1:0] ip);
        return cur_local_en && ip == cur_local_ip;
    endfunction

    function automatic int find_entry(int t, logic [IP_W-1:0] ip);
        int n;
        n = (t == REQ_TBL) ? REQ_ENTRIES : RSP_ENTRIES;
        for (int i = 0; i < n; i++)
            if (tbl_live[t][i] && tbl_ip[t][i] == ip)
                return i;
        return -1;
    endfunction

    function automatic bit insert_entry(int t, logic [IP_W-1:0] ip);
        int n;
        n = (t == REQ_TBL) ? REQ_ENTRIES : RSP_ENTRIES;
        for (int i = 0; i < n; i++)
        begin
            if (!tbl_live[t][i])
            begin
                tbl_live[t][i] = 1'b1;
                tbl_ip[t][i] = ip;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [3:0] header_fault(arp_pkt_t p);
        if (cur_hook == HOOK_OUTPUT)
            return CAUSE_PASSED;
        if (p.eth_source != p.sender_mac)
            return CAUSE_SRC_MISMATCH;
        if (p.arp_opcode == OP_REPLY && p.eth_dest != p.target_mac)
            return CAUSE_DST_MISMATCH;
        if (is_local(p.sender_ip))
            return CAUSE_LOCAL_SENDER;
        if (p.arp_opcode == OP_REQUEST)
        begin
            if (p.eth_dest != MAC_BROADCAST)
                return CAUSE_REQ_NOT_BCAST;
            if (p.target_mac != '0)
                return CAUSE_REQ_TMAC_SET;
        end
        if (p.arp_opcode == OP_REPLY)
        begin
            if (p.eth_dest == MAC_BROADCAST)
                return CAUSE_REPLY_BCAST;
            if (cur_hook == HOOK_FORWARD && is_local(p.target_ip))
                return CAUSE_FWD_TO_LOCAL;
        end
        return CAUSE_PASSED;
    endfunction

    function automatic filter_result_t judge_packet(arp_pkt_t p);
        filter_result_t r;
        int             slot;
        r.verdict = VERDICT_CONTINUE;
        r.cause = CAUSE_PASSED;
        r.insert_lost = 1'b0;
        if ((p.hw_type == HW_ETHERNET || p.hw_type == HW_IEEE802) &&
            p.proto_type == PROTO_IPV4)
        begin
            r.cause = header_fault(p);
            if (r.cause == CAUSE_PASSED && p.arp_opcode == OP_REQUEST)
            begin
                if (cur_hook == HOOK_INPUT)
                    r.cause = CAUSE_REQ_ON_INPUT;
                else if (cur_hook == HOOK_OUTPUT || cur_hook == HOOK_FORWARD)
                begin
                    if (find_entry(REQ_TBL, p.target_ip) < 0 &&
                        !insert_entry(REQ_TBL, p.target_ip))
                        r.insert_lost = 1'b1;
                end
            end
            else if (r.cause == CAUSE_PASSED && p.arp_opcode == OP_REPLY &&
                     (cur_hook == HOOK_INPUT || cur_hook == HOOK_FORWARD))
            begin
                slot = find_entry(REQ_TBL, p.sender_ip);
                if (slot >= 0)
                begin
                    tbl_live[REQ_TBL][slot] = 1'b0;
                    if (find_entry(RSP_TBL, p.sender_ip) < 0 &&
                        !insert_entry(RSP_TBL, p.sender_ip))
                        r.insert_lost = 1'b1;
                end
                else if (find_entry(RSP_TBL, p.sender_ip) < 0)
                    r.cause = CAUSE_UNSOLICITED;
            end
        end
        if (r.cause != CAUSE_PASSED)
            r.verdict = (cur_action > VERDICT_CONTINUE) ? VERDICT_DROP : cur_action;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < 40)
            $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    // Packet transfer side.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                verdicts_due.push_back(judge_packet(pkt_on_wire));
            if (!in_valid || in_ready)
            begin
                if (packets_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pkt_on_wire = packets_to_send.pop_front();
                    in_valid   <= 1'b1;
                    hw_type    <= pkt_on_wire.hw_type;
                    proto_type <= pkt_on_wire.proto_type;
                    arp_opcode <= pkt_on_wire.arp_opcode;
                    eth_source <= pkt_on_wire.eth_source;
                    eth_dest   <= pkt_on_wire.eth_dest;
                    sender_mac <= pkt_on_wire.sender_mac;
                    sender_ip  <= pkt_on_wire.sender_ip;
                    target_mac <= pkt_on_wire.target_mac;
                    target_ip  <= pkt_on_wire.target_ip;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_fired)
        begin
            hold_left <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
    end

    // Result transfer side.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("verdict %0d cause %0d with no packet outstanding",
                                              verdict, cause));
                else
                begin
                    due_now = verdicts_due.pop_front();
                    if (verdict !== due_now.verdict)
                        report_mismatch($sformatf("verdict %0d, predicted %0d (cause %0d)",
                                                  verdict, due_now.verdict, due_now.cause));
                    if (cause !== due_now.cause)
                        report_mismatch($sformatf("cause %0d, predicted %0d",
                                                  cause, due_now.cause));
                    if (insert_lost !== due_now.insert_lost)
                        report_mismatch($sformatf("insert_lost %0b, predicted %0b (cause %0d)",
                                                  insert_lost, due_now.insert_lost,
                                                  due_now.cause));
                    results_checked++;
                    if (due_now.insert_lost)
                        lost_seen++;
                    causes_seen[due_now.cause] = 1'b1;
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apply_settings(input logic [1:0] hook, input logic [1:0] action,
                                  input logic [IP_W-1:0] lip, input logic en);
        logic [IP_W-1:0]      vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        regs[0] = CFG_CHAIN_HOOK;
        regs[1] = CFG_FAIL_ACTION;
        regs[2] = CFG_LOCAL_IP;
        regs[3] = CFG_LOCAL_IP_ENABLE;
        vals[0] = IP_W'(hook);
        vals[1] = IP_W'(action);
        vals[2] = lip;
        vals[3] = IP_W'(en);
        @(posedge clk);
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_hook = hook;
        cur_action = action;
        cur_local_ip = lip;
        cur_local_en = en;
        settings_used++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (packets_to_send.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [IP_W-1:0] pool_ip(int k);
        return POOL_BASE + IP_W'(k);
    endfunction

    function automatic logic [IP_W-1:0] pick_ip(int wild_pct);
        int r;
        r = $urandom_range(99);
        if (r < wild_pct)
            return $urandom;
        if (r < wild_pct + 8)
            return cur_local_ip;
        return pool_ip($urandom_range(POOL_SIZE - 1));
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [MAC_W-1:0] m;
        m[31:0]  = $urandom;
        m[47:32] = 16'($urandom);
        return m;
    endfunction

    function automatic arp_pkt_t well_formed(bit is_reply, logic [IP_W-1:0] sip,
                                             logic [IP_W-1:0] tip);
        arp_pkt_t p;
        p.hw_type    = $urandom_range(1) ? HW_IEEE802 : HW_ETHERNET;
        p.proto_type = PROTO_IPV4;
        p.arp_opcode = is_reply ? OP_REPLY : OP_REQUEST;
        p.sender_mac = rand_mac();
        p.eth_source = p.sender_mac;
        p.sender_ip  = sip;
        p.target_ip  = tip;
        if (is_reply)
        begin
            p.target_mac = rand_mac();
            p.eth_dest   = p.target_mac;
        end
        else
        begin
            p.target_mac = '0;
            p.eth_dest   = MAC_BROADCAST;
        end
        return p;
    endfunction

    function automatic arp_pkt_t broken_packet();
        arp_pkt_t p;
        int       b;
        p = well_formed($urandom_range(1), pick_ip(10), pick_ip(10));
        b = $urandom_range(MAC_W - 1);
        case ($urandom_range(6))
            0: p.eth_source[b] = ~p.eth_source[b];
            1: p.eth_dest = rand_mac();
            2: p.target_mac = rand_mac();
            3:
            begin
                p.eth_dest   = MAC_BROADCAST;
                p.target_mac = MAC_BROADCAST;
            end
            4: p.sender_ip = cur_local_ip;
            5: p.target_ip = cur_local_ip;
            default: p.arp_opcode = 16'($urandom);
        endcase
        return p;
    endfunction

    function automatic arp_pkt_t noise_packet();
        arp_pkt_t p;
        p.hw_type    = 16'($urandom);
        p.proto_type = 16'($urandom);
        p.arp_opcode = 16'($urandom);
        p.eth_source = rand_mac();
        p.eth_dest   = rand_mac();
        p.sender_mac = rand_mac();
        p.sender_ip  = $urandom;
        p.target_mac = rand_mac();
        p.target_ip  = $urandom;
        if ($urandom_range(1))
        begin
            p.hw_type    = HW_ETHERNET;
            p.proto_type = PROTO_IPV4;
            if ($urandom_range(1))
                p.arp_opcode = 16'($urandom_range(3));
        end
        return p;
    endfunction

    function automatic logic [1:0] phase_hook(int ph);
        case (ph)
            0, 3, 7, 10: return HOOK_OUTPUT;
            1, 4, 9, 11: return HOOK_FORWARD;
            6:           return HOOK_UNKNOWN;
            default:     return HOOK_INPUT;
        endcase
    endfunction

    initial
    begin
        arp_pkt_t        p;
        int              r;
        logic [IP_W-1:0] lip;
        logic            en;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        apply_settings(HOOK_INPUT, VERDICT_DROP, pool_ip(5), 1'b1);
        p = well_formed(0, pool_ip(10), pool_ip(11));
        p.hw_type = 16'hFFFF;
        packets_to_send.push_back(p);
        p = well_formed(0, pool_ip(10), pool_ip(11));
        p.hw_type = HW_IEEE802;
        p.proto_type = 16'h0000;
        packets_to_send.push_back(p);
        p = well_formed(0, pool_ip(10), pool_ip(11));
        p.eth_source = ~p.sender_mac;
        packets_to_send.push_back(p);
        p = well_formed(1, pool_ip(10), pool_ip(11));
        p.eth_dest = '0;
        p.target_mac = MAC_BROADCAST >> 1;
        packets_to_send.push_back(p);
        packets_to_send.push_back(well_formed(1, pool_ip(5), pool_ip(12)));
        p = well_formed(0, pool_ip(10), pool_ip(11));
        p.eth_dest = '0;
        packets_to_send.push_back(p);
        p = well_formed(0, pool_ip(10), pool_ip(11));
        p.target_mac = MAC_BROADCAST;
        packets_to_send.push_back(p);
        p = well_formed(1, pool_ip(10), pool_ip(11));
        p.eth_dest = MAC_BROADCAST;
        p.target_mac = MAC_BROADCAST;
        packets_to_send.push_back(p);
        packets_to_send.push_back(well_formed(0, pool_ip(10), pool_ip(11)));
        packets_to_send.push_back(well_formed(1, pool_ip(13), pool_ip(11)));
        p = well_formed(0, pool_ip(10), pool_ip(11));
        p.arp_opcode = 16'hFFFF;
        packets_to_send.push_back(p);
        p = '{default: '0};
        packets_to_send.push_back(p);
        p = '{default: '1};
        packets_to_send.push_back(p);
        p = well_formed(1, 32'hFFFF_FFFF, 32'h0000_0000);
        p.sender_mac = '1;
        p.eth_source = '1;
        p.target_mac = '0;
        p.eth_dest = '0;
        packets_to_send.push_back(p);
        wait_drained();

        apply_settings(HOOK_OUTPUT, VERDICT_ACCEPT, pool_ip(1), 1'b1);
        p = well_formed(0, pool_ip(1), pool_ip(1));
        p.eth_source = '0;
        packets_to_send.push_back(p);
        packets_to_send.push_back(p);
        packets_to_send.push_back(well_formed(0, pool_ip(4), pool_ip(2)));
        packets_to_send.push_back(well_formed(1, pool_ip(2), pool_ip(4)));
        wait_drained();

        apply_settings(HOOK_FORWARD, VERDICT_CONTINUE, pool_ip(7), 1'b1);
        packets_to_send.push_back(well_formed(1, pool_ip(1), pool_ip(4)));
        packets_to_send.push_back(well_formed(1, pool_ip(1), pool_ip(4)));
        packets_to_send.push_back(well_formed(1, pool_ip(9), pool_ip(4)));
        packets_to_send.push_back(well_formed(1, pool_ip(2), pool_ip(7)));
        packets_to_send.push_back(well_formed(0, pool_ip(4), pool_ip(3)));
        wait_drained();

        apply_settings(HOOK_UNKNOWN, ACTION_UNKNOWN, 32'hFFFF_FFFF, 1'b0);
        packets_to_send.push_back(well_formed(0, pool_ip(4), pool_ip(3)));
        packets_to_send.push_back(well_formed(1, pool_ip(40), pool_ip(3)));
        p = well_formed(0, pool_ip(4), pool_ip(3));
        p.eth_source = p.sender_mac ^ 48'h1;
        packets_to_send.push_back(p);
        packets_to_send.push_back(well_formed(0, 32'hFFFF_FFFF, pool_ip(3)));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 58;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            en = ($urandom_range(3) != 0);
            lip = pool_ip($urandom_range(POOL_SIZE - 1));
            if (ph == 3)
            begin
                lip = '0;
                en = 1'b1;
            end
            else if (ph == 5)
            begin
                lip = '1;
                en = 1'b1;
            end
            else if (ph == 8)
                lip = $urandom;
            apply_settings(phase_hook(ph), 2'(ph % 4), lip, en);
            if (ph == 1)
                hold_arm = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                if (r < 42)
                    p = well_formed(0, pick_ip(10), pick_ip(2));
                else if (r < 84)
                    p = well_formed(1, pick_ip(6), pick_ip(10));
                else if (r < 93)
                    p = broken_packet();
                else
                    p = noise_packet();
                packets_to_send.push_back(p);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        $display("Checked %0d verdicts under %0d filter settings; %0d of 10 causes seen.",
                 results_checked, settings_used, $countones(causes_seen));
        $display("Lost table inserts flagged %0d times; receiver held off for %0d cycles once.",
                 lost_seen, HOLD_CYCLES);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
